@@ hw/rtl/bir_pkg.sv @@
// Package for the bencode info range scanner: widths, codes, state and result types.
package bir_pkg;

	localparam int POS_BITS   = 32;
	localparam int DEPTH_BITS = 16;
	localparam int KEY_LEN    = 6;

	localparam logic [7:0] CH_D     = 8'h64; // 'd'
	localparam logic [7:0] CH_L     = 8'h6c; // 'l'
	localparam logic [7:0] CH_E     = 8'h65; // 'e'
	localparam logic [7:0] CH_I     = 8'h69; // 'i'
	localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CH_NINE  = 8'h39; // '9'
	localparam logic [7:0] CH_FOUR  = 8'h34; // '4'
	localparam logic [7:0] CH_COLON = 8'h3a; // ':'
	localparam logic [7:0] CH_N     = 8'h6e; // 'n'
	localparam logic [7:0] CH_F     = 8'h66; // 'f'
	localparam logic [7:0] CH_O     = 8'h6f; // 'o'

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
	localparam logic [POS_BITS-1:0]   POS_MAX   = '1;

	typedef enum logic [2:0] {
		M_SEARCH = 3'd0,
		M_FIRST  = 3'd1,
		M_STRUCT = 3'd2,
		M_INT    = 3'd3,
		M_LEN    = 3'd4,
		M_SKIP   = 3'd5,
		M_DONE   = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_KEY    = 2'd1,
		ST_EARLY_END = 2'd2,
		ST_NOT_DICT  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]            key_cnt;
		mode_t                 mode;
		logic [DEPTH_BITS-1:0] depth;
		logic [POS_BITS-1:0]   skip;
		logic [POS_BITS-1:0]   pos;
		logic [POS_BITS-1:0]   vstart;
	} state_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        in_info;
		logic        range_done;
		logic [31:0] range_start;
		logic [31:0] range_end;
		status_t     scan_status;
	} result_t;

	localparam state_t STATE_RESET = '{
		key_cnt: 3'd0,
		mode:    M_SEARCH,
		depth:   '0,
		skip:    '0,
		pos:     '0,
		vstart:  '0
	};

	function automatic logic [7:0] key_byte(logic [2:0] idx);
		logic [7:0] k;
		unique case (idx)
			3'd0: k = CH_FOUR;
			3'd1: k = CH_COLON;
			3'd2: k = CH_I;
			3'd3: k = CH_N;
			3'd4: k = CH_F;
			3'd5: k = CH_O;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	// Report an offset on 32 bits: zero-extend or truncate.
	function automatic logic [31:0] pos_out(logic [POS_BITS-1:0] p);
		logic [POS_BITS+31:0] ext;
		ext = {32'd0, p};
		return ext[31:0];
	endfunction

endpackage

@@ hw/rtl/bir_core.sv @@
// Per-byte scanner step: next state and result word from the current state and one byte.
module bir_core import bir_pkg::*; (
	input  state_t     cur,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output state_t     nxt,
	output result_t    res
);

	state_t                step;
	logic                  info_flag;
	logic                  done;
	status_t               status;
	logic [POS_BITS-1:0]   rs;
	logic [POS_BITS-1:0]   re;
	logic                  is_digit;
	logic [POS_BITS-1:0]   digit;
	logic [POS_BITS+3:0]   acc;
	logic [POS_BITS-1:0]   pos_inc;
	logic [POS_BITS-1:0]   skip_dec;

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign digit    = {{(POS_BITS-8){1'b0}}, data_byte - CH_ZERO};
	assign acc      = ({4'd0, cur.skip} << 3) + ({4'd0, cur.skip} << 1) + {4'd0, digit};
	assign pos_inc  = cur.pos + 1'b1;
	assign skip_dec = (cur.skip != '0) ? cur.skip - 1'b1 : cur.skip;

	// Next state of the structure walk, before end-of-file handling.
	always_comb begin
		step      = cur;
		info_flag = 1'b0;
		done      = 1'b0;
		status    = ST_OK;
		rs        = '0;
		re        = '0;
		unique case (cur.mode)
			M_SEARCH: begin
				if (cur.key_cnt < 3'(KEY_LEN) && data_byte == key_byte(cur.key_cnt)) begin
					step.key_cnt = cur.key_cnt + 3'd1;
				end else begin
					step.key_cnt = (data_byte == CH_FOUR) ? 3'd1 : 3'd0;
				end
				if (step.key_cnt >= 3'(KEY_LEN) && !last_byte) begin
					step.mode   = M_FIRST;
					step.vstart = pos_inc;
				end
			end
			M_FIRST: begin
				if (data_byte == CH_D) begin
					info_flag  = 1'b1;
					step.depth = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
					step.mode  = M_STRUCT;
				end else begin
					done      = 1'b1;
					status    = ST_NOT_DICT;
					rs        = cur.vstart;
					re        = cur.vstart;
					step.mode = M_DONE;
				end
			end
			M_STRUCT: begin
				info_flag = 1'b1;
				priority if (data_byte == CH_D || data_byte == CH_L) begin
					if (cur.depth < DEPTH_MAX) step.depth = cur.depth + 1'b1;
				end else if (data_byte == CH_E) begin
					if (cur.depth <= {{(DEPTH_BITS-1){1'b0}}, 1'b1}) begin
						step.depth = '0;
						done       = 1'b1;
						status     = ST_OK;
						rs         = cur.vstart;
						re         = pos_inc;
						step.mode  = M_DONE;
					end else begin
						step.depth = cur.depth - 1'b1;
					end
				end else if (data_byte == CH_I) begin
					step.mode = M_INT;
				end else if (is_digit) begin
					step.skip = digit;
					step.mode = M_LEN;
				end else begin
					// Drop any other byte in structure position.
				end
			end
			M_INT: begin
				info_flag = 1'b1;
				if (data_byte == CH_E) step.mode = M_STRUCT;
			end
			M_LEN: begin
				info_flag = 1'b1;
				if (is_digit) begin
					step.skip = (acc[POS_BITS+3:POS_BITS] != 4'd0) ? POS_MAX : acc[POS_BITS-1:0];
				end else begin
					step.mode = (cur.skip == '0) ? M_STRUCT : M_SKIP;
				end
			end
			M_SKIP: begin
				info_flag = 1'b1;
				step.skip = skip_dec;
				if (skip_dec == '0) step.mode = M_STRUCT;
			end
			default: begin
			end
		endcase
	end

	// Fold in end of file: final report, then return to reset state.
	always_comb begin
		res.byte_out    = data_byte;
		res.in_info     = info_flag;
		res.range_done  = done;
		res.range_start = pos_out(rs);
		res.range_end   = pos_out(re);
		res.scan_status = status;
		nxt             = step;
		nxt.pos         = pos_inc;
		if (last_byte) begin
			nxt = STATE_RESET;
			if (!done && step.mode != M_DONE) begin
				res.range_done = 1'b1;
				if (step.mode == M_SEARCH) begin
					res.scan_status = ST_NO_KEY;
				end else begin
					res.scan_status = ST_EARLY_END;
					res.range_start = pos_out(step.vstart);
					res.range_end   = pos_out(pos_inc);
				end
			end
		end
	end

endmodule

@@ hw/rtl/bencode_info_range_scanner_top.sv @@
// Top level of the bencode info range scanner: input register, step logic, result register.
// A word accepted into the input register passes through bir_core into the result register.
// Throughput: one word per cycle while the output is not stalled; the byte state update is a single pass of bir_core.
// Output stall backs up through the input register to in_stall with no bubble.
// Reset (arst_n low, asynchronous): scanner returns to key search at offset zero,
// both pipeline stages empty. The state also returns to reset after every last byte.
module bencode_info_range_scanner_top import bir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_out,
	output logic        in_info,
	output logic        range_done,
	output logic [31:0] range_start,
	output logic [31:0] range_end,
	output logic [1:0]  scan_status
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Result register stage.
	logic       valid_s2;
	result_t    res_s2;

	// Scanner state, updated once per word leaving stage one.
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;

	logic       adv_s2;
	logic       adv_s1;
	logic       load_s1;

	// Stage two can take a word when it is empty or its word leaves now.
	assign adv_s2   = !valid_s2 || !out_stall;
	// Advance the stage-one word into the result register.
	assign adv_s1   = valid_s1 && adv_s2;
	// Hold the input when stage one is full and cannot drain.
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	bir_core u_core (
		.cur       (state_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign byte_out    = res_s2.byte_out;
	assign in_info     = res_s2.in_info;
	assign range_done  = res_s2.range_done;
	assign range_start = res_s2.range_start;
	assign range_end   = res_s2.range_end;
	assign scan_status = res_s2.scan_status;

	// Key search never leaves a full match or a nonzero depth behind.
	a_search_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == M_SEARCH |-> state_q.key_cnt < 3'(KEY_LEN) && state_q.depth == '0)
		else $error("search state holds stale match count or depth");

	// A word leaving stage one lands in the result register.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2 && res_s2.byte_out == $past(data_s1))
		else $error("stage one word lost on advance");

	// Status and offsets are zero unless the range is final.
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.range_done |->
			res_s2.scan_status == ST_OK && res_s2.range_start == 32'd0 &&
			res_s2.range_end == 32'd0)
		else $error("range fields set without range_done");

	// Key-not-found and not-a-dictionary bytes are never inside the value.
	a_outside: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.range_done &&
			(res_s2.scan_status == ST_NO_KEY || res_s2.scan_status == ST_NOT_DICT)
			|-> !res_s2.in_info)
		else $error("failed scan flagged a byte as inside the value");

endmodule

@@ dv/bencode_info_range_scanner_top_tb.sv @@
// Self-checking testbench for the bencode info range scanner: byte streams in, predicted words out.
module bencode_info_range_scanner_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bir_pkg::*;

	typedef logic [7:0] byte_list_t [$];

	// Idle cycles with no accepted word on either side before the run is declared hung.
	localparam int HANG_LIMIT    = 2000;
	// The block holds a word in its input and result registers; drain on before the final check.
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_WORDS  = 450;
	localparam int REPORT_LIMIT  = 10;
	// Length of the run of opening brackets in the nesting file.
	localparam int DEEP_OPEN     = 24;

	// Scoreboard: tracks the scan state of the current file and queues the words it predicts.
	class info_range_tracker;
		result_t               pending[$];
		int                    errors;
		int                    shown;
		logic [7:0]            info_key [KEY_LEN];
		logic [2:0]            key_cnt;
		mode_t                 mode;
		logic [DEPTH_BITS-1:0] depth;
		logic [POS_BITS-1:0]   skip;
		logic [POS_BITS-1:0]   pos;
		logic [POS_BITS-1:0]   vstart;

		function new();
			info_key = '{CH_FOUR, CH_COLON, CH_I, CH_N, CH_F, CH_O};
			errors   = 0;
			shown    = 0;
			restart();
		endfunction

		function void restart();
			key_cnt = '0;
			mode    = M_SEARCH;
			depth   = '0;
			skip    = '0;
			pos     = '0;
			vstart  = '0;
		endfunction

		function bit is_numeral(logic [7:0] c);
			return (c >= CH_ZERO) && (c <= CH_NINE);
		endfunction

		// Advance the scan by one accepted byte and queue the word it should produce.
		function void note_byte(logic [7:0] c, logic last);
			result_t             exp;
			logic [POS_BITS-1:0] digit;
			logic [POS_BITS-1:0] rs;
			logic [POS_BITS-1:0] re;
			exp             = '0;
			exp.byte_out    = c;
			exp.scan_status = ST_OK;
			rs              = '0;
			re              = '0;
			digit           = '0;
			digit[7:0]      = c - CH_ZERO;
			case (mode)
				M_SEARCH: begin
					if ((key_cnt < KEY_LEN) && (c == info_key[key_cnt]))
						key_cnt++;
					else
						key_cnt = (c == CH_FOUR) ? 3'd1 : 3'd0;
					// A key on the very last byte of the file does not open a value.
					if ((key_cnt >= KEY_LEN) && !last) begin
						mode   = M_FIRST;
						vstart = pos + 1'b1;
					end
				end
				M_FIRST: begin
					if (c == CH_D) begin
						exp.in_info = 1'b1;
						depth       = DEPTH_BITS'(1);
						mode        = M_STRUCT;
					end else begin
						exp.range_done  = 1'b1;
						exp.scan_status = ST_NOT_DICT;
						rs              = vstart;
						re              = vstart;
						mode            = M_DONE;
					end
				end
				M_STRUCT: begin
					exp.in_info = 1'b1;
					if ((c == CH_D) || (c == CH_L)) begin
						if (depth < DEPTH_MAX)
							depth++;
					end else if (c == CH_E) begin
						if (depth <= 1) begin
							depth          = '0;
							exp.range_done = 1'b1;
							rs             = vstart;
							re             = pos + 1'b1;
							mode           = M_DONE;
						end else begin
							depth--;
						end
					end else if (c == CH_I) begin
						mode = M_INT;
					end else if (is_numeral(c)) begin
						skip = digit;
						mode = M_LEN;
					end
				end
				M_INT: begin
					exp.in_info = 1'b1;
					if (c == CH_E)
						mode = M_STRUCT;
				end
				M_LEN: begin
					exp.in_info = 1'b1;
					if (is_numeral(c)) begin
						if (skip > (POS_MAX - digit) / 10)
							skip = POS_MAX;
						else
							skip = skip * 10 + digit;
					end else begin
						// Any non-digit ends the length and is eaten as the separator.
						mode = (skip == 0) ? M_STRUCT : M_SKIP;
					end
				end
				M_SKIP: begin
					exp.in_info = 1'b1;
					if (skip > 0)
						skip--;
					if (skip == 0)
						mode = M_STRUCT;
				end
				default: begin
				end
			endcase
			if (last) begin
				if (!exp.range_done && (mode != M_DONE)) begin
					exp.range_done = 1'b1;
					if (mode == M_SEARCH) begin
						exp.scan_status = ST_NO_KEY;
					end else begin
						exp.scan_status = ST_EARLY_END;
						rs              = vstart;
						re              = pos + 1'b1;
					end
				end
				restart();
			end else begin
				pos = pos + 1'b1;
			end
			exp.range_start = rs;
			exp.range_end   = re;
			pending.push_back(exp);
		endfunction

		// Compare one output word with the oldest prediction.
		function void check_word(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (shown < REPORT_LIMIT) begin
					shown++;
					$display("output word with nothing pending: byte %02h", got.byte_out);
				end
				return;
			end
			exp = pending.pop_front();
			if ((got.byte_out !== exp.byte_out) || (got.in_info !== exp.in_info) ||
				(got.range_done !== exp.range_done) ||
				(got.range_start !== exp.range_start) ||
				(got.range_end !== exp.range_end) ||
				(got.scan_status !== exp.scan_status)) begin
				errors++;
				if (shown < REPORT_LIMIT) begin
					shown++;
					$display("mismatch exp/got: byte %02h/%02h info %b/%b done %b/%b",
						exp.byte_out, got.byte_out, exp.in_info, got.in_info,
						exp.range_done, got.range_done);
					$display("  start %0d/%0d end %0d/%0d status %0d/%0d",
						exp.range_start, got.range_start, exp.range_end, got.range_end,
						exp.scan_status, got.scan_status);
				end
			end
		endfunction

		function void flag_leftover();
			if (pending.size() != 0) begin
				errors += pending.size();
				$display("%0d predicted words never came out", pending.size());
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  byte_out;
	logic        in_info;
	logic        range_done;
	logic [31:0] range_start;
	logic [31:0] range_end;
	logic [1:0]  scan_status;

	info_range_tracker tracker;
	byte_list_t        file_bytes;
	bit                quiet;
	int                sent;
	int                hang_count;

	bencode_info_range_scanner_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_out    (byte_out),
		.in_info     (in_info),
		.range_done  (range_done),
		.range_start (range_start),
		.range_end   (range_end),
		.scan_status (scan_status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap length for either side: mostly none or short, now and then long.
	// A quiet stretch drops all idling so back-to-back words get exercised too.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one word, hold it until accepted, then record it in the scoreboard.
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_byte(b, l);
		sent++;
	endtask

	// Stream a whole file; the final byte carries the last flag.
	task automatic send_file(ref byte_list_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	function automatic void push_key(ref byte_list_t q);
		q.push_back(CH_FOUR);
		q.push_back(CH_COLON);
		q.push_back(CH_I);
		q.push_back(CH_N);
		q.push_back(CH_F);
		q.push_back(CH_O);
	endfunction

	function automatic void push_number(ref byte_list_t q, input int unsigned n);
		string s;
		s = $sformatf("%0d", n);
		foreach (s[i])
			q.push_back(s[i]);
	endfunction

	function automatic void push_random(ref byte_list_t q, input int n);
		repeat (n)
			q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Byte string: length digits, separator (usually a colon), then arbitrary data.
	function automatic void push_string(ref byte_list_t q);
		int unsigned len;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
		push_number(q, len);
		if ($urandom_range(0, 9) == 0)
			q.push_back(8'($urandom_range(0, 255)));
		else
			q.push_back(CH_COLON);
		push_random(q, len);
	endfunction

	function automatic void push_dict(ref byte_list_t q, input int lvl);
		int n;
		n = $urandom_range(0, 3);
		q.push_back(CH_D);
		repeat (n) begin
			// Drop a stray byte in structure position now and then.
			if ($urandom_range(0, 9) == 0)
				q.push_back(8'($urandom_range(0, 255)));
			push_string(q);
			push_value(q, lvl + 1);
		end
		q.push_back(CH_E);
	endfunction

	function automatic void push_value(ref byte_list_t q, input int lvl);
		int r;
		int n;
		r = (lvl >= 3) ? $urandom_range(5, 9) : $urandom_range(0, 9);
		if (r < 3) begin
			push_dict(q, lvl);
		end else if (r < 5) begin
			n = $urandom_range(0, 3);
			q.push_back(CH_L);
			repeat (n)
				push_value(q, lvl + 1);
			q.push_back(CH_E);
		end else if (r < 7) begin
			q.push_back(CH_I);
			if ($urandom_range(0, 3) == 0)
				q.push_back(8'h2d);
			push_number(q, $urandom_range(0, 999));
			q.push_back(CH_E);
		end else begin
			push_string(q);
		end
	endfunction

	// Build one random file: mostly well-formed info dictionaries, the rest broken shapes.
	function automatic void build_file(ref byte_list_t q);
		int         r;
		int         base;
		int         cut;
		logic [7:0] b;
		q.delete();
		r = $urandom_range(0, 99);
		push_random(q, $urandom_range(0, 4));
		// Start a false key so the matcher has to fall back.
		if ($urandom_range(0, 4) == 0) begin
			q.push_back(CH_FOUR);
			q.push_back(CH_COLON);
			q.push_back(CH_I);
		end
		if (r < 60) begin
			push_key(q);
			push_dict(q, 0);
			push_random(q, $urandom_range(0, 3));
		end else if (r < 72) begin
			// Cut the value short so the file ends inside it.
			push_key(q);
			base = q.size();
			push_dict(q, 0);
			cut = $urandom_range(base + 1, q.size() - 1);
			while (q.size() > cut)
				q.pop_back();
		end else if (r < 80) begin
			push_key(q);
			do
				b = 8'($urandom_range(0, 255));
			while (b == CH_D);
			q.push_back(b);
			push_random(q, $urandom_range(0, 4));
		end else if (r < 86) begin
			push_key(q);
		end else if (r < 93) begin
			push_random(q, $urandom_range(1, 12));
		end else begin
			// Oversized string length that can saturate the counter, then end the file early.
			push_key(q);
			q.push_back(CH_D);
			q.push_back(8'(CH_ZERO + $urandom_range(4, 9)));
			repeat ($urandom_range(8, 11))
				q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
			q.push_back(($urandom_range(0, 1) == 0) ? CH_COLON : 8'($urandom_range(0, 255)));
			push_random(q, $urandom_range(0, 5));
		end
		if (q.size() == 0)
			q.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Output side: stall in bursts of random length with ready stretches between.
	initial begin
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Check every word the block hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_word(result_t'({byte_out, in_info, range_done, range_start,
				range_end, scan_status}));
	end

	// Watchdog: any accepted word on either side restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			hang_count <= 0;
		else
			hang_count <= hang_count + 1;
		if (hang_count >= HANG_LIMIT) begin
			$display("bencode_info_range_scanner_top_tb: errors");
			$finish;
		end
	end

	initial begin
		int random_base;
		tracker    = new();
		quiet      = 1'b0;
		sent       = 0;
		in_valid   <= 1'b0;
		data_byte  <= 8'h00;
		last_byte  <= 1'b0;
		arst_n     <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single zero byte that is also the last: no key anywhere.
		file_bytes = {8'h00};
		send_file(file_bytes);
		// Key whose final byte ends the file: it must not count.
		file_bytes = {CH_FOUR, CH_COLON, CH_I, CH_N, CH_F, CH_O};
		send_file(file_bytes);
		// Value opens with a list bracket, not a dictionary; the trailing 0xff is ignored.
		file_bytes = {CH_FOUR, CH_COLON, CH_I, CH_N, CH_F, CH_O, CH_L, 8'hff};
		send_file(file_bytes);
		// Dictionary with an odd separator, a skipped string and integer, then a byte after done.
		file_bytes = {CH_FOUR, CH_COLON, CH_I, CH_N, CH_F, CH_O, CH_D, 8'h33, 8'hff,
			8'h61, 8'h62, 8'h63, CH_I, 8'h35, CH_E, CH_E, 8'h7a};
		send_file(file_bytes);

		random_base = sent;
		while (sent - random_base < RANDOM_WORDS) begin
			quiet = ($urandom_range(0, 7) == 0);
			build_file(file_bytes);
			send_file(file_bytes);
		end

		// Nesting: open a long run of brackets, then close them all and add a byte after done.
		quiet = 1'b1;
		file_bytes.delete();
		push_key(file_bytes);
		repeat (DEEP_OPEN)
			file_bytes.push_back(CH_D);
		repeat (DEEP_OPEN)
			file_bytes.push_back(CH_E);
		file_bytes.push_back(8'h7a);
		send_file(file_bytes);
		quiet = 1'b0;

		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		tracker.flag_leftover();
		if (tracker.errors == 0)
			$display("bencode_info_range_scanner_top_tb: clean");
		else
			$display("bencode_info_range_scanner_top_tb: errors");
		$finish;
	end

endmodule
